### hw/rtl/ssr_pkg.sv
`default_nettype none

package ssr_pkg;

   // Fixed by the 64-bit pattern / replacement registers and their 4-bit lengths
   localparam int unsigned TEXT_MAX     = 8;
   localparam int unsigned LEN_W        = 4;
   localparam int unsigned BYTES_W      = 8 * TEXT_MAX;
   localparam int unsigned RESULT_IDX_W = 3;
   localparam int unsigned COUNT_W      = 16;

   localparam int unsigned PATTERN_MAX_DEFAULT     = 8;
   localparam int unsigned REPLACEMENT_MAX_DEFAULT = 8;

   // Command queue between front and back
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = 2;

   // Configuration port
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 64;

   localparam logic [1:0] REG_PATTERN_BYTES      = 2'd0;
   localparam logic [1:0] REG_PATTERN_LENGTH     = 2'd1;
   localparam logic [1:0] REG_REPLACEMENT_BYTES  = 2'd2;
   localparam logic [1:0] REG_REPLACEMENT_LENGTH = 2'd3;

   // Settings as the datapath sees them (lengths already clamped)
   typedef struct packed {
      logic [BYTES_W-1:0] pattern;
      logic [LEN_W-1:0]   plen;
      logic [BYTES_W-1:0] repl;
      logic [LEN_W-1:0]   rlen;
      logic               window_clear;
   } cfg_type;

   // One queued command: a burst of up to TEXT_MAX bytes, zero bytes = end marker
   typedef struct packed {
      logic [BYTES_W-1:0] bytes;
      logic [LEN_W-1:0]   nbytes;
      logic               last;
      logic [COUNT_W-1:0] count;
      logic               no_match;
   } cmd_type;

endpackage

`default_nettype wire

### hw/rtl/ssr_csr.sv
`default_nettype none

module ssr_csr #(
   parameter int unsigned PATTERN_MAX     = ssr_pkg::PATTERN_MAX_DEFAULT,
   parameter int unsigned REPLACEMENT_MAX = ssr_pkg::REPLACEMENT_MAX_DEFAULT
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire  [ssr_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire  [ssr_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ssr_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output ssr_pkg::cfg_type                  cfg
);

   logic [ssr_pkg::BYTES_W-1:0] pattern_ff, pattern_in;
   logic [ssr_pkg::LEN_W-1:0]   plen_ff, plen_in;
   logic [ssr_pkg::BYTES_W-1:0] repl_ff, repl_in;
   logic [ssr_pkg::LEN_W-1:0]   rlen_ff, rlen_in;
   logic                        wr;
   logic [1:0]                  idx;

   assign wr  = csr_psel & csr_penable & csr_pwrite;
   assign idx = csr_paddr[4:3];

   always_comb begin
      pattern_in = pattern_ff;
      plen_in    = plen_ff;
      repl_in    = repl_ff;
      rlen_in    = rlen_ff;
      if (wr) begin
         unique case (idx)
            ssr_pkg::REG_PATTERN_BYTES:      pattern_in = csr_pwdata[ssr_pkg::BYTES_W-1:0];
            ssr_pkg::REG_PATTERN_LENGTH:     plen_in    = csr_pwdata[ssr_pkg::LEN_W-1:0];
            ssr_pkg::REG_REPLACEMENT_BYTES:  repl_in    = csr_pwdata[ssr_pkg::BYTES_W-1:0];
            ssr_pkg::REG_REPLACEMENT_LENGTH: rlen_in    = csr_pwdata[ssr_pkg::LEN_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         plen_ff    <= ssr_pkg::LEN_W'(1);
         repl_ff    <= '0;
         rlen_ff    <= '0;
      end else begin
         pattern_ff <= pattern_in;
         plen_ff    <= plen_in;
         repl_ff    <= repl_in;
         rlen_ff    <= rlen_in;
      end
   end

   always_comb begin
      unique case (idx)
         ssr_pkg::REG_PATTERN_BYTES:      csr_prdata = ssr_pkg::CSR_DATA_W'(pattern_ff);
         ssr_pkg::REG_PATTERN_LENGTH:     csr_prdata = ssr_pkg::CSR_DATA_W'(plen_ff);
         ssr_pkg::REG_REPLACEMENT_BYTES:  csr_prdata = ssr_pkg::CSR_DATA_W'(repl_ff);
         ssr_pkg::REG_REPLACEMENT_LENGTH: csr_prdata = ssr_pkg::CSR_DATA_W'(rlen_ff);
      endcase
   end

   // Clamp lengths: pattern to 1..PATTERN_MAX, replacement to 0..REPLACEMENT_MAX
   always_comb begin
      cfg.pattern = pattern_ff;
      cfg.repl    = repl_ff;
      if (plen_ff == '0)
         cfg.plen = ssr_pkg::LEN_W'(1);
      else if (plen_ff > ssr_pkg::LEN_W'(PATTERN_MAX))
         cfg.plen = ssr_pkg::LEN_W'(PATTERN_MAX);
      else
         cfg.plen = plen_ff;
      if (rlen_ff > ssr_pkg::LEN_W'(REPLACEMENT_MAX))
         cfg.rlen = ssr_pkg::LEN_W'(REPLACEMENT_MAX);
      else
         cfg.rlen = rlen_ff;
      // new pattern length drops whatever the window held
      cfg.window_clear = wr && (idx == ssr_pkg::REG_PATTERN_LENGTH);
   end

endmodule

`default_nettype wire

### hw/rtl/ssr_front.sv
`default_nettype none

module ssr_front #(
   parameter int unsigned PATTERN_MAX = ssr_pkg::PATTERN_MAX_DEFAULT
) (
   input  wire                    clock,
   input  wire                    reset,
   input  ssr_pkg::cfg_type       cfg,
   input  wire                    in_valid,
   output logic                   in_ready,
   input  wire  [7:0]             in_byte,
   input  wire                    in_last,
   input  wire                    queue_full,
   output logic                   push,
   output ssr_pkg::cmd_type       cmd
);

   localparam int unsigned FILL_W = $clog2(PATTERN_MAX + 1);

   logic [7:0]                  win_ff [PATTERN_MAX];
   logic [7:0]                  win_in [PATTERN_MAX];
   logic [7:0]                  tmp    [PATTERN_MAX];
   logic [FILL_W-1:0]           fill_ff, fill_in;
   logic [ssr_pkg::COUNT_W-1:0] count_ff, count_in, count_next;
   logic [FILL_W-1:0]           plen_f, fill_cur, nfill;
   logic [ssr_pkg::BYTES_W-1:0] win_bytes;
   logic                        accept, full_win, hit, miss;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;
   assign plen_f   = cfg.plen[FILL_W-1:0];
   assign fill_cur = (fill_ff >= plen_f) ? '0 : fill_ff;
   assign nfill    = fill_cur + FILL_W'(1);
   assign full_win = (nfill == plen_f);

   always_comb begin
      win_bytes = '0;
      hit       = 1'b1;
      for (int k = 0; k < int'(PATTERN_MAX); k++) begin
         tmp[k] = (k == int'(fill_cur)) ? in_byte : win_ff[k];
         win_bytes[8*k +: 8] = tmp[k];
         if (k < int'(cfg.plen) && tmp[k] != cfg.pattern[8*k +: 8])
            hit = 1'b0;
      end
      hit  = hit && full_win;
      miss = full_win && !hit;
   end

   assign count_next = (hit && count_ff != '1) ? count_ff + 1'b1 : count_ff;

   always_comb begin
      // window after this byte: oldest drops out on a mismatch
      for (int k = 0; k < int'(PATTERN_MAX) - 1; k++)
         win_in[k] = miss ? tmp[k+1] : tmp[k];
      win_in[PATTERN_MAX-1] = tmp[PATTERN_MAX-1];

      if (hit)       fill_in = '0;
      else if (miss) fill_in = plen_f - FILL_W'(1);
      else           fill_in = nfill;
      count_in = count_next;

      cmd.last     = in_last;
      cmd.count    = in_last ? count_next : '0;
      cmd.no_match = in_last && (count_next == '0);
      if (hit) begin
         cmd.bytes  = cfg.repl;
         cmd.nbytes = cfg.rlen;
      end else if (miss) begin
         // the oldest byte; at end of text the rest of the window follows it
         cmd.bytes  = win_bytes;
         cmd.nbytes = in_last ? cfg.plen : ssr_pkg::LEN_W'(1);
      end else begin
         cmd.bytes  = win_bytes;
         cmd.nbytes = in_last ? ssr_pkg::LEN_W'(nfill) : '0;
      end
      if (in_last) begin
         fill_in  = '0;
         count_in = '0;
      end
      push = accept && (in_last || cmd.nbytes != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (cfg.window_clear)
            fill_ff <= '0;
         else if (accept)
            fill_ff <= fill_in;
         if (accept)
            count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept)
         win_ff <= win_in;
   end

endmodule

`default_nettype wire

### hw/rtl/ssr_queue.sv
`default_nettype none

module ssr_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  ssr_pkg::cmd_type       push_cmd,
   output logic                   full,
   input  wire                    pop,
   output ssr_pkg::cmd_type       head,
   output logic                   empty
);

   localparam int unsigned PW = ssr_pkg::QUEUE_PTR_W;

   ssr_pkg::cmd_type mem_ff [ssr_pkg::QUEUE_DEPTH];
   logic [PW:0]      wr_ptr_ff, rd_ptr_ff;

   assign empty = (wr_ptr_ff == rd_ptr_ff);
   assign full  = (wr_ptr_ff[PW] != rd_ptr_ff[PW]) &&
                  (wr_ptr_ff[PW-1:0] == rd_ptr_ff[PW-1:0]);
   assign head  = mem_ff[rd_ptr_ff[PW-1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (push && !full)
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop && !empty)
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full)
         mem_ff[wr_ptr_ff[PW-1:0]] <= push_cmd;
   end

endmodule

`default_nettype wire

### hw/rtl/ssr_back.sv
`default_nettype none

module ssr_back (
   input  wire                          clock,
   input  wire                          reset,
   input  ssr_pkg::cmd_type             head,
   input  wire                          empty,
   output logic                         pop,
   output logic                         out_valid,
   input  wire                          out_ready,
   output logic [7:0]                   out_byte,
   output logic                         byte_valid,
   output logic                         out_last,
   output logic [ssr_pkg::COUNT_W-1:0]  match_count,
   output logic                         no_match
);

   ssr_pkg::cmd_type                cur_ff;
   logic                            busy_ff;
   logic [ssr_pkg::RESULT_IDX_W-1:0] idx_ff;
   logic [ssr_pkg::LEN_W-1:0]       last_idx;
   logic                            final_res, take;

   // a command of zero bytes still yields one result: the end marker
   assign last_idx  = (cur_ff.nbytes == '0) ? '0 : cur_ff.nbytes - 1'b1;
   assign final_res = (ssr_pkg::LEN_W'(idx_ff) == last_idx);
   assign take      = busy_ff && out_ready;
   assign pop       = !empty && (!busy_ff || (take && final_res));

   assign out_valid   = busy_ff;
   assign byte_valid  = (cur_ff.nbytes != '0);
   assign out_byte    = byte_valid ? cur_ff.bytes[8*idx_ff +: 8] : 8'd0;
   assign out_last    = cur_ff.last && final_res;
   assign match_count = out_last ? cur_ff.count : '0;
   assign no_match    = out_last && cur_ff.no_match;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (pop) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (take) begin
         if (final_res)
            busy_ff <= 1'b0;
         else
            idx_ff <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop)
         cur_ff <= head;
   end

endmodule

`default_nettype wire

### hw/rtl/string_search_replace.sv
// Path: an accepted text byte is written into the command queue, then into the back's command register.
// Throughput: one text byte per cycle while the command queue is not full;
//   results leave at one per cycle while rsp_tready is high, so a replacement
//   or the end-of-text flush holds results while the queue (4 deep) takes input.
// Reset: synchronous, active high; clears window fill, match count, queue and
//   output state, and sets the registers to their reset values.
`default_nettype none

module string_search_replace #(
   parameter int unsigned PATTERN_MAX     = ssr_pkg::PATTERN_MAX_DEFAULT,
   parameter int unsigned REPLACEMENT_MAX = ssr_pkg::REPLACEMENT_MAX_DEFAULT
) (
   input  wire                             clock,
   input  wire                             reset,

   // Text in. tdata: [7:0] text_byte. tlast: text_last.
   input  wire                             req_tvalid,
   output logic                            req_tready,
   input  wire  [7:0]                      req_tdata,
   input  wire                             req_tlast,

   // Edited text out.
   // tdata: [7:0] out_byte, [23:8] match_count, [24] no_match, [31:25] zero.
   // tuser: [0] byte_valid. tlast: out_last.
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   output logic [31:0]                     rsp_tdata,
   output logic                            rsp_tuser,
   output logic                            rsp_tlast,

   // Register port: 0x00 pattern, 0x08 pattern length,
   // 0x10 replacement, 0x18 replacement length
   input  wire                             csr_psel,
   input  wire                             csr_penable,
   input  wire                             csr_pwrite,
   input  wire  [ssr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire  [ssr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ssr_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   ssr_pkg::cfg_type            cfg;
   ssr_pkg::cmd_type            push_cmd, head;
   logic                        push, pop, full, empty;
   logic [7:0]                  out_byte;
   logic                        byte_valid, out_last, no_match;
   logic [ssr_pkg::COUNT_W-1:0] match_count;

   assign csr_pready = 1'b1;

   ssr_csr #(
      .PATTERN_MAX     (PATTERN_MAX),
      .REPLACEMENT_MAX (REPLACEMENT_MAX)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   // Front: window compare, one byte per transfer, emits burst commands
   ssr_front #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .queue_full (full),
      .push       (push),
      .cmd        (push_cmd)
   );

   ssr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (full),
      .pop      (pop),
      .head     (head),
      .empty    (empty)
   );

   // Back: expands each command into result transfers
   ssr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .empty       (empty),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_byte    (out_byte),
      .byte_valid  (byte_valid),
      .out_last    (out_last),
      .match_count (match_count),
      .no_match    (no_match)
   );

   assign rsp_tdata = {7'd0, no_match, match_count, out_byte};
   assign rsp_tuser = byte_valid;
   assign rsp_tlast = out_last;

endmodule

`default_nettype wire

### hw/rtl/ssr_checker.sv
`default_nettype none

module ssr_checker (
   input  wire        clock,
   input  wire        reset,
   input  wire        rsp_tvalid,
   input  wire        rsp_tready,
   input  wire [31:0] rsp_tdata,
   input  wire        rsp_tuser,
   input  wire        rsp_tlast
);

   // an empty end marker only closes a text
   a_marker_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("end marker without tlast");

   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[7:0] == 8'd0)
      else $error("end marker carries a byte");

   a_status_only_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[24:8] == 17'd0)
      else $error("count or no_match set before end of text");

   a_no_match_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[24] == (rsp_tdata[23:8] == 16'd0))
      else $error("no_match disagrees with match_count");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under backpressure");

endmodule

bind string_search_replace ssr_checker u_ssr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

### test/ssr_edit_checker.sv
`timescale 1ns / 1ps

module ssr_edit_checker (
   input  wire                             clock,
   input  wire                             reset,

   input  wire                             req_tvalid,
   input  wire                             req_tready,
   input  wire  [7:0]                      req_tdata,   // [7:0] text_byte
   input  wire                             req_tlast,

   input  wire                             rsp_tvalid,
   input  wire                             rsp_tready,
   input  wire  [31:0]                     rsp_tdata,   // [7:0] out_byte, [23:8] match_count,
                                                        // [24] no_match, [31:25] zero
   input  wire                             rsp_tuser,   // [0] byte_valid
   input  wire                             rsp_tlast,

   input  wire                             csr_psel,
   input  wire                             csr_penable,
   input  wire                             csr_pwrite,
   input  wire  [ssr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire  [ssr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   input  wire                             csr_pready,

   output int                              fail_count,
   output int                              pending_count,
   output int                              checked_count
);

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        out_last;
      logic [15:0] match_count;
      logic        no_match;
   } edit_result_type;

   // shadow registers
   logic [63:0] pattern_reg;
   logic [3:0]  pattern_len_reg;
   logic [63:0] repl_reg;
   logic [3:0]  repl_len_reg;

   // shadow datapath state
   logic [7:0]  window_bytes [8];
   int unsigned window_fill;
   logic [15:0] match_total;

   edit_result_type edited_bytes_due [$];

   function automatic edit_result_type byte_result(input logic [7:0] value,
                                                   input logic valid);
      edit_result_type r;
      r = '0;
      r.out_byte   = value;
      r.byte_valid = valid;
      return r;
   endfunction

   // One text byte in, zero or more edited-text transfers out.
   task automatic predict_edit(input logic [7:0] text_byte, input logic text_last);
      int unsigned     plen;
      int unsigned     rlen;
      int unsigned     k;
      logic            hit;
      edit_result_type tail;
      edit_result_type step_out [$];
      plen = pattern_len_reg;
      if (plen == 0) plen = 1;
      if (plen > 8) plen = 8;
      rlen = repl_len_reg;
      if (rlen > 8) rlen = 8;

      if (window_fill >= plen) window_fill = 0;
      window_bytes[window_fill] = text_byte;
      window_fill++;

      if (window_fill == plen) begin
         hit = 1'b1;
         for (k = 0; k < plen; k++)
            if (window_bytes[k] != pattern_reg[8*k +: 8]) hit = 1'b0;
         if (hit) begin
            for (k = 0; k < rlen; k++)
               step_out.push_back(byte_result(repl_reg[8*k +: 8], 1'b1));
            window_fill = 0;
            if (match_total != 16'hFFFF) match_total++;
         end else begin
            step_out.push_back(byte_result(window_bytes[0], 1'b1));
            for (k = 1; k < plen; k++) window_bytes[k-1] = window_bytes[k];
            window_fill--;
         end
      end

      if (text_last) begin
         for (k = 0; k < window_fill; k++)
            step_out.push_back(byte_result(window_bytes[k], 1'b1));
         // nothing left to send: lone end marker
         if (step_out.size() == 0) step_out.push_back(byte_result(8'h00, 1'b0));
         tail = step_out.pop_back();
         tail.out_last    = 1'b1;
         tail.match_count = match_total;
         tail.no_match    = (match_total == 16'd0);
         step_out.push_back(tail);
         window_fill = 0;
         match_total = '0;
      end

      foreach (step_out[i]) edited_bytes_due.push_back(step_out[i]);
   endtask

   task automatic check_field(input string field, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      edit_result_type due;
      if (reset) begin
         pattern_reg     = '0;
         pattern_len_reg = 4'd1;
         repl_reg        = '0;
         repl_len_reg    = 4'd0;
         window_fill     = 0;
         match_total     = '0;
         edited_bytes_due.delete();
      end else begin
         // results first: a byte taken at this edge cannot show up before the next one
         if (rsp_tvalid && rsp_tready) begin
            if (edited_bytes_due.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected transfer, expected none, actual tdata 0x%h tuser %b tlast %b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
            end else begin
               due = edited_bytes_due.pop_front();
               checked_count++;
               check_field("out_byte",    due.out_byte,    rsp_tdata[7:0]);
               check_field("byte_valid",  due.byte_valid,  rsp_tuser);
               check_field("out_last",    due.out_last,    rsp_tlast);
               check_field("match_count", due.match_count, rsp_tdata[23:8]);
               check_field("no_match",    due.no_match,    rsp_tdata[24]);
               check_field("tdata pad",   0,               rsp_tdata[31:25]);
            end
         end

         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:3])
               ssr_pkg::REG_PATTERN_BYTES:      pattern_reg = csr_pwdata;
               ssr_pkg::REG_PATTERN_LENGTH: begin
                  pattern_len_reg = csr_pwdata[3:0];
                  window_fill     = 0;
               end
               ssr_pkg::REG_REPLACEMENT_BYTES:  repl_reg = csr_pwdata;
               ssr_pkg::REG_REPLACEMENT_LENGTH: repl_len_reg = csr_pwdata[3:0];
               default: ;
            endcase
         end

         if (req_tvalid && req_tready) predict_edit(req_tdata, req_tlast);
      end
      pending_count = edited_bytes_due.size();
   end

endmodule

### test/string_search_replace_tb.sv
`timescale 1ns / 1ps

module string_search_replace_tb;

   // generous bound: a few hundred bytes of up to eight results each under
   // heavy stalls plus the register writes, taken many times over
   localparam int CYCLE_LIMIT       = 100000;
   localparam int HOLD_OFF_CYCLES   = 120;   // long receiver stall, fills the command queue
   localparam int LATENCY_PAUSE     = 8;     // covers bytes that leave nothing behind
   localparam int ITEMS_PER_REGIME  = 100;

   logic                           clock       = 1'b0;
   logic                           reset       = 1'b1;

   logic                           req_tvalid  = 1'b0;
   logic                           req_tready;
   logic [7:0]                     req_tdata   = '0;   // [7:0] text_byte
   logic                           req_tlast   = 1'b0;

   logic                           rsp_tvalid;
   logic                           rsp_tready  = 1'b0;
   logic [31:0]                    rsp_tdata;          // [7:0] out_byte, [23:8] match_count,
                                                       // [24] no_match, [31:25] zero
   logic                           rsp_tuser;          // [0] byte_valid
   logic                           rsp_tlast;

   logic                           csr_psel    = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite  = 1'b0;
   logic [ssr_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [ssr_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [ssr_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   int fail_count;
   int pending_count;
   int checked_count;

   // idle percentages for each side; recv_idle_pct is read by the receiver
   // process on the same edge it is written, so it only ever changes via <=
   int send_idle_pct     = 14;
   int recv_idle_pct     = 62;
   int hold_off_requests = 0;
   int hold_off_served   = 0;
   int texts_sent        = 0;
   int bytes_sent        = 0;
   int cycles            = 0;

   string_search_replace dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Watches all three ports, predicts and compares; hands back counts only.
   ssr_edit_checker u_edit_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   always #1 clock = ~clock;

   // Watchdog: a hang anywhere (lost result, stuck tready) ends here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timed out after %0d cycles, %0d results outstanding",
                  $time, cycles, pending_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver. Random tready at the configured idle rate; on request it
   // holds tready low for a long stretch counted here, independent of the sender.
   initial begin : receiver
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (hold_off_requests != hold_off_served) begin
            hold_off_served++;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // One text byte transfer. Called at a falling edge, returns at a falling
   // edge with no assignment made there, so back-to-back calls keep tvalid
   // high without a second update in the same step.
   task automatic send_text_byte(input logic [7:0] value, input logic ends);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= ends;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      bytes_sent++;
      if (ends) texts_sent++;
   endtask

   // tlast goes on the final byte only when the text is meant to end here.
   task automatic send_text(input logic [7:0] text [$], input logic ends);
      foreach (text[i]) send_text_byte(text[i], ends && (i == text.size() - 1));
   endtask

   // Sender stops and waits for every expected transfer, then a short pause
   // so that bytes still sitting in the window pipeline settle.
   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (LATENCY_PAUSE) @(negedge clock);
   endtask

   // Two-phase register write: setup, then access until pready.
   task automatic write_register(input logic [1:0] index, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   initial begin : stimulus
      logic [7:0]  text [$];
      logic [63:0] pattern;
      int unsigned plen_w;
      int unsigned plen_eff;
      int unsigned rlen_w;
      int unsigned pick;
      int unsigned text_len;
      int unsigned prefix_len;
      int unsigned regime;
      int unsigned regime_items;
      int unsigned k;

      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---------------- directed ----------------
      // Reset settings: pattern 0x00, one byte, empty replacement. Both zero
      // bytes are deleted; the last one leaves nothing, so an empty end marker.
      text = '{8'h00, 8'hFF, 8'h00};
      send_text(text, 1'b1);
      wait_for_idle();

      // "ab" -> "XYZ": overlapping start "aab", then a trailing byte flushed at end
      write_register(ssr_pkg::REG_PATTERN_BYTES,      64'h6261);
      write_register(ssr_pkg::REG_PATTERN_LENGTH,     64'd2);
      write_register(ssr_pkg::REG_REPLACEMENT_BYTES,  64'h5A5958);
      write_register(ssr_pkg::REG_REPLACEMENT_LENGTH, 64'd3);
      text = '{8'h61, 8'h61, 8'h62, 8'h62};
      send_text(text, 1'b1);
      // single-byte text with no occurrence: no_match set
      text = '{8'h71};
      send_text(text, 1'b1);
      wait_for_idle();

      // pattern length 0 acts as 1 ('a'); replacement length 12 clamps to 8,
      // so one byte in gives the longest burst out
      write_register(ssr_pkg::REG_PATTERN_LENGTH,     64'd0);
      write_register(ssr_pkg::REG_REPLACEMENT_BYTES,  64'hFF00_8001_7F10_EF01);
      write_register(ssr_pkg::REG_REPLACEMENT_LENGTH, 64'd12);
      text = '{8'h61};
      send_text(text, 1'b1);
      wait_for_idle();

      // all-ones pattern, length 15 clamps to 8, deletion: full window match
      // on the last byte -> empty end marker with count 1
      write_register(ssr_pkg::REG_PATTERN_BYTES,      '1);
      write_register(ssr_pkg::REG_PATTERN_LENGTH,     64'd15);
      write_register(ssr_pkg::REG_REPLACEMENT_LENGTH, 64'd0);
      text.delete();
      repeat (8) text.push_back(8'hFF);
      send_text(text, 1'b1);
      wait_for_idle();

      // Pattern length rewritten mid-text: "ab" sits in the window and is
      // dropped by the write, only "c" comes out.
      write_register(ssr_pkg::REG_PATTERN_BYTES,      64'h636261);
      write_register(ssr_pkg::REG_PATTERN_LENGTH,     64'd3);
      write_register(ssr_pkg::REG_REPLACEMENT_BYTES,  64'h2D);
      write_register(ssr_pkg::REG_REPLACEMENT_LENGTH, 64'd1);
      text = '{8'h61, 8'h62};
      send_text(text, 1'b0);
      wait_for_idle();
      write_register(ssr_pkg::REG_PATTERN_LENGTH,     64'd3);
      text = '{8'h63};
      send_text(text, 1'b1);
      wait_for_idle();

      // ---------------- backpressure ----------------
      // Every 'a' becomes 8 bytes. The receiver stalls for a long stretch while
      // the sender keeps offering, so the command queue fills and req_tready
      // drops. Halfway the sender pauses mid-text until everything has drained.
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      write_register(ssr_pkg::REG_PATTERN_BYTES,      64'h61);
      write_register(ssr_pkg::REG_PATTERN_LENGTH,     64'd1);
      write_register(ssr_pkg::REG_REPLACEMENT_BYTES,  {$urandom, $urandom});
      write_register(ssr_pkg::REG_REPLACEMENT_LENGTH, 64'd8);
      hold_off_requests <= hold_off_requests + 1;
      text.delete();
      repeat (12) text.push_back(8'h61);
      send_text(text, 1'b0);
      wait_for_idle();
      send_text(text, 1'b1);
      wait_for_idle();

      // ---------------- random ----------------
      // Three idle regimes: sender light / receiver heavy, swapped, then none.
      for (regime = 0; regime < 3; regime++) begin
         case (regime)
            0: begin
               send_idle_pct = 14;
               recv_idle_pct <= 62;
            end
            1: begin
               send_idle_pct = 62;
               recv_idle_pct <= 14;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct <= 0;
            end
         endcase
         regime_items = 0;
         while (regime_items < ITEMS_PER_REGIME) begin
            // Settings: mostly short patterns over a three-letter alphabet so
            // that matches are common; now and then the length corner values.
            pick = $urandom_range(99);
            if (pick < 80)      plen_w = $urandom_range(1, 4);
            else if (pick < 90) plen_w = $urandom_range(5, 8);
            else if (pick < 95) plen_w = 0;
            else                plen_w = $urandom_range(9, 15);
            plen_eff = (plen_w == 0) ? 1 : ((plen_w > 8) ? 8 : plen_w);
            for (k = 0; k < 8; k++)
               pattern[8*k +: 8] = ($urandom_range(9) < 7) ? 8'(8'h61 + $urandom_range(2))
                                                           : 8'($urandom_range(255));
            rlen_w = ($urandom_range(9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
            write_register(ssr_pkg::REG_PATTERN_BYTES,      pattern);
            write_register(ssr_pkg::REG_PATTERN_LENGTH,     64'(plen_w));
            write_register(ssr_pkg::REG_REPLACEMENT_BYTES,  {$urandom, $urandom});
            write_register(ssr_pkg::REG_REPLACEMENT_LENGTH, 64'(rlen_w));

            repeat ($urandom_range(1, 4)) begin
               // Texts built from whole occurrences, broken prefixes,
               // alphabet bytes and full-range noise.
               text.delete();
               text_len = $urandom_range(1, 24);
               while (text.size() < text_len) begin
                  pick = $urandom_range(99);
                  if (pick < 35) begin
                     for (k = 0; k < plen_eff; k++) text.push_back(pattern[8*k +: 8]);
                  end else if (pick < 50 && plen_eff > 1) begin
                     prefix_len = $urandom_range(1, plen_eff - 1);
                     for (k = 0; k < prefix_len; k++) text.push_back(pattern[8*k +: 8]);
                  end else if (pick < 85) begin
                     text.push_back(8'(8'h61 + $urandom_range(2)));
                  end else begin
                     text.push_back(8'($urandom_range(255)));
                  end
               end
               send_text(text, 1'b1);
               regime_items += text.size();
            end
            wait_for_idle();
         end
      end

      $display("Covered %0d texts (%0d bytes) over clamped lengths, deletion, end markers,",
               texts_sent, bytes_sent);
      $display("mid-text rewrite, queue-full stall and three idle mixes; %0d transfers checked.",
               checked_count);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
